FILE: design/assert_macros.svh
// assertion macros used by the checker file ita_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/ita_pkg.sv
// shared types, constants and the digit-to-ascii function for integer_to_ascii_digits
// no dependencies
package ita_pkg;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 8;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int DIGITS_W = 4 * DEC_DIGITS;
  localparam int CNT_W    = 4;
  localparam int BIT_CNT_W = 5;

  // conversion codes
  localparam logic [ACTION_W-1:0] ACT_SDEC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UDEC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HEXL = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_HEXU = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_SIGN,
    ST_EMIT
  } ita_state_t;

  // one digit (0..15) to its ascii character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] dig, input logic upper);
    logic [CHAR_W-1:0] res;
    begin
      if (dig < 4'd10) begin
        res = CHAR_ZERO + {4'd0, dig};
      end else if (upper) begin
        res = CHAR_UPPER_A + {4'd0, dig - 4'd10};
      end else begin
        res = CHAR_LOWER_A + {4'd0, dig - 4'd10};
      end
      return res;
    end
  endfunction

endpackage

FILE: design/integer_to_ascii_digits.sv
// Sequence: decimal items run one shift-and-add-3 step per value bit, then drop leading
// zeros while keeping at least one digit, then register a minus sign if negative and then
// one character per digit. Hex items skip the conversion. The output register holds while
// stalled, and a new item is taken only once the last character is registered. Sync
// active-low reset clears the sequencer and the output valid; depends on ita_pkg
module integer_to_ascii_digits (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ita_pkg::ACTION_W-1:0]  in_action,
  input  logic [ita_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ita_pkg::CHAR_W-1:0]    out_char_out,
  output logic                          out_last
);
  import ita_pkg::*;

  ita_state_t            state_r, state_nxt;
  logic [VALUE_W-1:0]    mag_r, mag_nxt;
  logic [DIGITS_W-1:0]   digits_r, digits_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  upper_r, upper_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_xfer;
  logic                  out_free;
  logic                  in_neg;
  logic [VALUE_W-1:0]    in_mag;
  logic [DIGITS_W-1:0]   adj;
  logic                  top_zero;
  logic                  is_hex;

  assign in_ready     = (state_r == ST_IDLE);
  assign in_xfer      = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

  // sign and magnitude of the incoming value
  assign in_neg = (in_action == ACT_SDEC) && in_value[VALUE_W-1];
  assign in_mag = in_neg ? (~in_value + 32'd1) : in_value;
  assign is_hex = (in_action == ACT_HEXL) || (in_action == ACT_HEXU);

  assign top_zero = (digits_r[DIGITS_W-1 -: 4] == 4'd0);

  // add-3 correction on every bcd digit ahead of the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (digits_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digits_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digits_r[4*i +: 4];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = is_hex ? ST_STRIP : ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == '0) begin
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!(top_zero && cnt_r > 4'd1)) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && cnt_r == 4'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    mag_nxt       = mag_r;
    digits_nxt    = digits_r;
    cnt_nxt       = cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt     = in_neg;
          upper_nxt   = (in_action == ACT_HEXU);
          bit_cnt_nxt = BIT_CNT_W'(VALUE_W - 1);
          if (is_hex) begin
            digits_nxt = {in_mag, 8'd0};
            cnt_nxt    = CNT_W'(HEX_DIGITS);
            mag_nxt    = '0;
          end else begin
            digits_nxt = '0;
            cnt_nxt    = CNT_W'(DEC_DIGITS);
            mag_nxt    = in_mag;
          end
        end
      end
      ST_CONV: begin
        // one shift-and-add-3 step per cycle
        digits_nxt  = {adj[DIGITS_W-2:0], mag_r[VALUE_W-1]};
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
      end
      ST_STRIP: begin
        // drop leading zeros, keep at least one digit
        if (top_zero && cnt_r > 4'd1) begin
          digits_nxt = {digits_r[DIGITS_W-5:0], 4'd0};
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(digits_r[DIGITS_W-1 -: 4], upper_r);
          out_last_nxt  = (cnt_r == 4'd1);
          digits_nxt    = {digits_r[DIGITS_W-5:0], 4'd0};
          cnt_nxt       = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    digits_r   <= digits_nxt;
    cnt_r      <= cnt_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: design/ita_checker.sv
// port-level checks for integer_to_ascii_digits, bound into every integer_to_ascii_digits instance
// depends on ita_pkg and assert_macros.svh
`include "assert_macros.svh"

module ita_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [ita_pkg::ACTION_W-1:0] in_action,
  input logic [ita_pkg::VALUE_W-1:0]  in_value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ita_pkg::CHAR_W-1:0]   out_char_out,
  input logic                         out_last
);
  import ita_pkg::*;

  // a stalled result holds its character
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char_out))

  // the block is busy right after taking an item
  `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

  // a minus sign never ends a number
  `ASSERT_IMPLY(a_minus_not_last, clk, rst_n, out_valid && out_char_out == CHAR_MINUS, !out_last)

  // the final character is never the sign
  `ASSERT_IMPLY(a_last_is_digit, clk, rst_n, out_valid && out_last, out_char_out != CHAR_MINUS)

endmodule

bind integer_to_ascii_digits ita_checker u_ita_checker (.*);

FILE: dv/testbench.sv
// self-checking testbench for integer_to_ascii_digits: number to ascii text conversion
// depends on ita_pkg and the integer_to_ascii_digits rtl

// predicts the character stream of each number and checks the block's output against it
class text_scoreboard;
  typedef struct packed {
    logic [ita_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } ascii_char_t;

  ascii_char_t pending_chars[$];
  int unsigned bad_chars;

  function new();
    bad_chars = 0;
  endfunction

  // expand one accepted number into the characters it should produce
  function void note_number(logic [ita_pkg::ACTION_W-1:0] action,
                            logic [ita_pkg::VALUE_W-1:0] value);
    logic [ita_pkg::VALUE_W-1:0] mag;
    logic [ita_pkg::VALUE_W-1:0] radix;
    logic [ita_pkg::VALUE_W-1:0] dig;
    logic [ita_pkg::CHAR_W-1:0]  ch;
    logic [ita_pkg::CHAR_W-1:0]  digits[$];
    logic                        upper;
    ascii_char_t                 entry;
    mag = value;
    upper = (action == ita_pkg::ACT_HEXU);
    radix = (action == ita_pkg::ACT_HEXL || action == ita_pkg::ACT_HEXU) ? 32'd16 : 32'd10;
    // signed decimal: leading minus, then the magnitude modulo 2^32
    if (action == ita_pkg::ACT_SDEC && value[ita_pkg::VALUE_W-1]) begin
      entry.ch = ita_pkg::CHAR_MINUS;
      entry.last = 1'b0;
      pending_chars.push_back(entry);
      mag = 32'd0 - value;
    end
    if (mag == 0) begin
      digits.push_back(ita_pkg::CHAR_ZERO);
    end
    // digits come out least significant first, so build the text from the front
    while (mag != 0) begin
      dig = mag % radix;
      if (dig < 10) begin
        ch = ita_pkg::CHAR_ZERO + dig[ita_pkg::CHAR_W-1:0];
      end else if (upper) begin
        ch = ita_pkg::CHAR_UPPER_A + dig[ita_pkg::CHAR_W-1:0] - 8'd10;
      end else begin
        ch = ita_pkg::CHAR_LOWER_A + dig[ita_pkg::CHAR_W-1:0] - 8'd10;
      end
      digits.push_front(ch);
      mag = mag / radix;
    end
    foreach (digits[i]) begin
      entry.ch = digits[i];
      entry.last = (i == digits.size() - 1);
      pending_chars.push_back(entry);
    end
  endfunction

  // compare one output transfer with the oldest pending character
  function void check_char(logic [ita_pkg::CHAR_W-1:0] ch, logic last);
    ascii_char_t want;
    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected char_out %h last %b, nothing pending", $time, ch, last);
      bad_chars++;
      return;
    end
    want = pending_chars.pop_front();
    if (want.ch !== ch) begin
      $display("%0t: char_out expected %h actual %h", $time, want.ch, ch);
      bad_chars++;
    end
    if (want.last !== last) begin
      $display("%0t: last expected %b actual %b", $time, want.last, last);
      bad_chars++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_NUMBERS = 187;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 60;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ita_pkg::ACTION_W-1:0]  in_action = ita_pkg::ACT_SDEC;
  logic [ita_pkg::VALUE_W-1:0]   in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ita_pkg::CHAR_W-1:0]    out_char_out;
  logic                          out_last;

  text_scoreboard sb = new();
  logic           steady_flow = 1'b0;
  int unsigned    quiet_cycles = 0;

  logic [ita_pkg::ACTION_W-1:0] conversions[4] =
    '{ita_pkg::ACT_SDEC, ita_pkg::ACT_UDEC, ita_pkg::ACT_HEXL, ita_pkg::ACT_HEXU};
  logic [ita_pkg::VALUE_W-1:0] corner_values[12] =
    '{32'h0000_0000, 32'h0000_0001, 32'h0000_0009, 32'h0000_000A, 32'h0000_000F,
      32'h0000_0010, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd999999999,
      32'd1000000000, 32'hC465_3600};

  integer_to_ascii_digits dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // send one number, holding it until the input transfer
  task automatic send_number(logic [ita_pkg::ACTION_W-1:0] action,
                             logic [ita_pkg::VALUE_W-1:0] value);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_number(action, value);
  endtask

  // random value with a spread of lengths, signs and corner values
  function automatic logic [ita_pkg::VALUE_W-1:0] pick_value();
    logic [ita_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
      default: v = corner_values[$urandom_range(0, 11)];
    endcase
    return v;
  endfunction

  // output side with random stalls
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_char(out_char_out, out_last);
    end
  end

  // reset, directed numbers, random numbers, then drain
  initial begin
    int drain;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // signed decimal corners, most negative value among them
    send_number(ita_pkg::ACT_SDEC, 32'h0000_0000);
    send_number(ita_pkg::ACT_SDEC, 32'h0000_0001);
    send_number(ita_pkg::ACT_SDEC, 32'hFFFF_FFFF);
    send_number(ita_pkg::ACT_SDEC, 32'h8000_0000);
    send_number(ita_pkg::ACT_SDEC, 32'h7FFF_FFFF);
    send_number(ita_pkg::ACT_SDEC, 32'd1000000000);
    send_number(ita_pkg::ACT_SDEC, 32'hC465_3600);
    // unsigned decimal
    send_number(ita_pkg::ACT_UDEC, 32'h0000_0000);
    send_number(ita_pkg::ACT_UDEC, 32'hFFFF_FFFF);
    send_number(ita_pkg::ACT_UDEC, 32'h8000_0000);
    send_number(ita_pkg::ACT_UDEC, 32'h0000_0009);
    send_number(ita_pkg::ACT_UDEC, 32'h0000_000A);
    send_number(ita_pkg::ACT_UDEC, 32'd1000000000);
    // hex, both letter cases
    send_number(ita_pkg::ACT_HEXL, 32'h0000_0000);
    send_number(ita_pkg::ACT_HEXL, 32'hFFFF_FFFF);
    send_number(ita_pkg::ACT_HEXL, 32'hABCD_EF09);
    send_number(ita_pkg::ACT_HEXL, 32'h0000_0010);
    send_number(ita_pkg::ACT_HEXL, 32'h0000_000F);
    send_number(ita_pkg::ACT_HEXU, 32'h0000_0000);
    send_number(ita_pkg::ACT_HEXU, 32'hFFFF_FFFF);
    send_number(ita_pkg::ACT_HEXU, 32'hABCD_EF09);
    send_number(ita_pkg::ACT_HEXU, 32'h8000_0000);
    send_number(ita_pkg::ACT_HEXU, 32'h0000_0001);

    // random part, alternating idle and back-to-back stretches
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      steady_flow = ((n / 35) % 3 == 2);
      send_number(conversions[$urandom_range(0, 3)], pick_value());
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;

    // wait for the last characters, then a short quiet window
    while (sb.pending_chars.size() != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);
    if (sb.bad_chars == 0 && sb.pending_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
